[rtl/vss_pkg.sv]
// Shared types and constants for the voice steal selector.
package vss_pkg;

    localparam int IDX_W      = 5;
    localparam int PRIO_IN_W  = 8;
    localparam int MAXV_W     = 6;
    localparam logic [MAXV_W-1:0] MAXV_RESET = 6'd32;

    typedef enum logic {
        OP_WRITE   = 1'b0,
        OP_REQUEST = 1'b1
    } op_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DRAIN,
        ST_EVAL
    } state_t;

endpackage

[rtl/vss_if.sv]
// Request, result and configuration channel interfaces.
interface vss_in_if;
    logic                           valid;
    logic                           ready;
    logic                           operation;
    logic [vss_pkg::IDX_W-1:0]      voice_index;
    logic                           live;
    logic                           looping;
    logic [vss_pkg::PRIO_IN_W-1:0]  priority_req;

    modport source (output valid, operation, voice_index, live, looping, priority_req,
                    input ready);
    modport sink   (input valid, operation, voice_index, live, looping, priority_req,
                    output ready);
endinterface

interface vss_out_if;
    logic                       valid;
    logic                       ready;
    logic                       stolen_valid;
    logic [vss_pkg::IDX_W-1:0]  stolen_index;
    logic                       last;

    modport source (output valid, stolen_valid, stolen_index, last, input ready);
    modport sink   (input valid, stolen_valid, stolen_index, last, output ready);
endinterface

interface vss_cfg_if;
    logic                       valid;
    logic                       ready;
    logic [vss_pkg::MAXV_W-1:0] max_voices;

    modport source (output valid, max_voices, input ready);
    modport sink   (input valid, max_voices, output ready);
endinterface

[rtl/vss_ram.sv]
// Generic single-port-write, single-port-read RAM with registered read data.
module vss_ram #(
    parameter int WIDTH = 10,
    parameter int DEPTH = 32
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

[rtl/voice_steal_selector.sv]
// Voice steal selector: slot table in RAM, scanned once per stolen voice.
// Sequence: a write request is taken in IDLE. A capacity request runs
//   one scan pass (SCAN, DRAIN, EVAL) per stolen voice plus one final pass.
// Throughput: one request at a time; the next is taken once the last result
//   is loaded into the output register. The RAM read port sets the scan rate.
// Reset: slot table reads as empty (per-slot valid flops), max_voices = 32.
module voice_steal_selector #(
    parameter int NUM_SLOTS     = 32,
    parameter int PRIORITY_BITS = 8
) (
    input  logic        clk,
    input  logic        rst_n,
    vss_in_if.sink      in_ch,
    vss_out_if.source   out_ch,
    vss_cfg_if.sink     cfg
);

    localparam int AW = $clog2(NUM_SLOTS);
    localparam int EW = PRIORITY_BITS + 2;
    localparam int CW = $clog2(NUM_SLOTS + 1);
    localparam int IW = vss_pkg::IDX_W;

    vss_pkg::state_t state_reg, state_next;

    logic [vss_pkg::MAXV_W-1:0] maxv_reg;
    logic [NUM_SLOTS-1:0]       slot_vld_reg;
    logic [IW-1:0]              req_idx_reg;
    logic [AW-1:0]              scan_addr_reg;
    logic                       stage_vld_reg;
    logic [AW-1:0]              stage_addr_reg;
    logic [CW-1:0]              cnt_reg;
    logic                       cand_found_reg;
    logic [AW-1:0]              cand_idx_reg;
    logic                       cand_loop_reg;
    logic [PRIORITY_BITS-1:0]   cand_prio_reg;
    logic                       pend_vld_reg;
    logic [AW-1:0]              pend_idx_reg;
    logic                       out_valid_reg;
    logic                       out_sv_reg;
    logic [IW-1:0]              out_idx_reg;
    logic                       out_last_reg;

    logic                     ram_we;
    logic [AW-1:0]            ram_waddr;
    logic [EW-1:0]            ram_wdata;
    logic                     ram_re;
    logic [EW-1:0]            ram_rdata;

    logic                     in_acc;
    logic                     wr_acc;
    logic                     req_acc;
    logic                     out_free;
    logic                     steal;
    logic                     eval_act;
    logic                     emit;
    logic                     e_live;
    logic                     e_loop;
    logic [PRIORITY_BITS-1:0] e_prio;
    logic                     consider;
    logic                     better;
    logic                     scan_start;

    vss_ram #(
        .WIDTH (EW),
        .DEPTH (NUM_SLOTS)
    ) u_table (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (scan_addr_reg),
        .rdata (ram_rdata)
    );

    assign in_acc  = in_ch.valid && in_ch.ready;
    assign req_acc = in_acc && (in_ch.operation == vss_pkg::OP_REQUEST);
    assign wr_acc  = in_acc && (in_ch.operation == vss_pkg::OP_WRITE)
                     && (32'(in_ch.voice_index) < NUM_SLOTS);

    // never-written slots read as empty
    assign e_live = ram_rdata[EW-1] && slot_vld_reg[stage_addr_reg];
    assign e_loop = ram_rdata[EW-2];
    assign e_prio = ram_rdata[PRIORITY_BITS-1:0];

    assign consider = stage_vld_reg && e_live
                      && (32'(stage_addr_reg) != 32'(req_idx_reg));
    assign better   = !cand_found_reg || (!e_loop && cand_loop_reg)
                      || ((e_loop == cand_loop_reg) && (e_prio < cand_prio_reg));

    assign steal    = cand_found_reg && (32'(cnt_reg) >= 32'(maxv_reg));
    assign out_free = !out_valid_reg || out_ch.ready;

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            vss_pkg::ST_IDLE:
            begin
                if (req_acc)
                begin
                    state_next = vss_pkg::ST_SCAN;
                end
            end
            vss_pkg::ST_SCAN:
            begin
                if (scan_addr_reg == AW'(NUM_SLOTS - 1))
                begin
                    state_next = vss_pkg::ST_DRAIN;
                end
            end
            vss_pkg::ST_DRAIN:
            begin
                state_next = vss_pkg::ST_EVAL;
            end
            vss_pkg::ST_EVAL:
            begin
                if (eval_act)
                begin
                    state_next = steal ? vss_pkg::ST_SCAN : vss_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = vss_pkg::ST_IDLE;
            end
        endcase
    end

    // outputs and RAM control
    always_comb
    begin
        in_ch.ready = 1'b0;
        ram_re      = 1'b0;
        ram_we      = 1'b0;
        ram_waddr   = cand_idx_reg;
        ram_wdata   = {1'b0, cand_loop_reg, cand_prio_reg};
        eval_act    = 1'b0;
        case (state_reg)
            vss_pkg::ST_IDLE:
            begin
                in_ch.ready = 1'b1;
                ram_we      = wr_acc;
                ram_waddr   = AW'(in_ch.voice_index);
                ram_wdata   = {in_ch.live, in_ch.looping,
                               PRIORITY_BITS'(in_ch.priority_req)};
            end
            vss_pkg::ST_SCAN:
            begin
                ram_re = 1'b1;
            end
            vss_pkg::ST_DRAIN:
            begin
                ram_re = 1'b0;
            end
            vss_pkg::ST_EVAL:
            begin
                // a held result or the final result needs room in the output register
                eval_act = (steal && !pend_vld_reg) || out_free;
                ram_we   = eval_act && steal;
            end
            default:
            begin
                in_ch.ready = 1'b0;
            end
        endcase
    end

    assign emit       = eval_act && (pend_vld_reg || !steal);
    assign scan_start = req_acc || (eval_act && steal);

    assign cfg.ready           = 1'b1;
    assign out_ch.valid        = out_valid_reg;
    assign out_ch.stolen_valid = out_sv_reg;
    assign out_ch.stolen_index = out_idx_reg;
    assign out_ch.last         = out_last_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= vss_pkg::ST_IDLE;
            maxv_reg       <= vss_pkg::MAXV_RESET;
            slot_vld_reg   <= '0;
            scan_addr_reg  <= '0;
            stage_vld_reg  <= 1'b0;
            cnt_reg        <= '0;
            cand_found_reg <= 1'b0;
            pend_vld_reg   <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            stage_vld_reg <= ram_re;
            if (cfg.valid && cfg.ready)
            begin
                maxv_reg <= cfg.max_voices;
            end
            if (wr_acc)
            begin
                slot_vld_reg[AW'(in_ch.voice_index)] <= 1'b1;
            end
            if (scan_start)
            begin
                scan_addr_reg <= '0;
            end
            else if (ram_re)
            begin
                scan_addr_reg <= AW'(scan_addr_reg + 1'b1);
            end
            if (scan_start)
            begin
                cnt_reg        <= '0;
                cand_found_reg <= 1'b0;
            end
            else if (consider)
            begin
                cnt_reg <= CW'(cnt_reg + 1'b1);
                if (better)
                begin
                    cand_found_reg <= 1'b1;
                end
            end
            if (req_acc)
            begin
                pend_vld_reg <= 1'b0;
            end
            else if (eval_act)
            begin
                pend_vld_reg <= steal;
            end
            if (emit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ch.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        stage_addr_reg <= scan_addr_reg;
        if (req_acc)
        begin
            req_idx_reg <= in_ch.voice_index;
        end
        if (!scan_start && consider && better)
        begin
            cand_idx_reg  <= stage_addr_reg;
            cand_loop_reg <= e_loop;
            cand_prio_reg <= e_prio;
        end
        if (eval_act && steal)
        begin
            pend_idx_reg <= cand_idx_reg;
        end
        if (emit)
        begin
            out_sv_reg   <= pend_vld_reg;
            out_idx_reg  <= pend_vld_reg ? IW'(pend_idx_reg) : '0;
            out_last_reg <= !steal;
        end
    end

endmodule
